// ===== rtl/pcfl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfl_pkg
// Shared types and codes of the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcfl_pkg;

	// command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_INIT  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOMEM  = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	// classified operation kinds passed from front to back
	localparam logic [1:0] K_REPORT = 2'd0;
	localparam logic [1:0] K_PUSH   = 2'd1;
	localparam logic [1:0] K_ALLOC  = 2'd2;
	localparam logic [1:0] K_INIT   = 2'd3;

	// configuration register indexes
	localparam int          CFG_IDX_W   = 1;
	localparam logic [0:0]  CFG_MEM_BASE = 1'd0;
	localparam logic [0:0]  CFG_MEM_TOP  = 1'd1;

	localparam logic [31:0] MEM_BASE_RST = 32'h8000_0000;
	localparam logic [31:0] MEM_TOP_RST  = 32'h8800_0000;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  cpu_id;
		logic [31:0] page_address;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted_address;
		logic [2:0]  source_cpu;
	} result_t;

endpackage

// ===== rtl/pcfl_ram.sv =====
// ----------------------------------------------------------------------------
// pcfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcfl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/pcfl_fifo.sv =====
// ----------------------------------------------------------------------------
// pcfl_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module pcfl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/pcfl_front.sv =====
// ----------------------------------------------------------------------------
// pcfl_front
// Classifies a request: folds the CPU index, checks a freed address and
// turns it into a page number, and sizes an init range in pages.
// ----------------------------------------------------------------------------
module pcfl_front #(
	parameter int NUM_CPUS   = 8,
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  pcfl_pkg::item_t  item,
	input  logic [31:0]      mem_base,
	input  logic [31:0]      mem_top,
	input  logic [32:0]      base,
	output logic [4+((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1)+$clog2(MAX_PAGES+1)-1:0] op_data
);

	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int PW = $clog2(MAX_PAGES + 1);
	localparam int SH = $clog2(PAGE_BYTES);

	typedef struct packed {
		logic [1:0]    kind;
		logic [1:0]    status;
		logic [CW-1:0] cpu;
		logic [PW-1:0] page;
	} op_t;

	op_t         op;
	logic [6:0]  cpu_fold;
	logic        aligned;
	logic        in_range;
	logic [33:0] page_idx;
	logic        idx_ok;
	logic        top_ok;
	logic [33:0] span;
	logic [PW-1:0] init_cnt;

	// fold cpu_id into the CPU range by repeated subtraction
	always_comb begin
		cpu_fold = 7'(item.cpu_id);
		for (int i = 0; i < 7; i++) begin
			if (cpu_fold >= 7'(NUM_CPUS)) begin
				cpu_fold = cpu_fold - 7'(NUM_CPUS);
			end
		end
	end

	assign aligned  = (item.page_address[SH-1:0] == '0);
	assign in_range = (item.page_address >= mem_base) && (item.page_address < mem_top);
	assign page_idx = 34'(item.page_address[31:SH]) - 34'(base[32:SH]);
	assign idx_ok   = (page_idx < 34'(MAX_PAGES));

	// base is page aligned, so whole pages below the top is a difference of page numbers
	assign top_ok = ({1'b0, mem_top} >= base);
	assign span   = 34'(mem_top[31:SH]) - 34'(base[32:SH]);
	always_comb begin
		if (!top_ok) begin
			init_cnt = '0;
		end else if (span > 34'(MAX_PAGES)) begin
			init_cnt = PW'(MAX_PAGES);
		end else begin
			init_cnt = PW'(span);
		end
	end

	always_comb begin
		op.kind   = pcfl_pkg::K_REPORT;
		op.status = pcfl_pkg::ST_OK;
		op.cpu    = cpu_fold[CW-1:0];
		op.page   = '0;
		case (item.command)
			pcfl_pkg::CMD_ALLOC: begin
				op.kind = pcfl_pkg::K_ALLOC;
			end
			pcfl_pkg::CMD_FREE: begin
				if (aligned && in_range && idx_ok) begin
					op.kind = pcfl_pkg::K_PUSH;
					op.page = PW'(page_idx);
				end else begin
					op.status = pcfl_pkg::ST_REJECT;
				end
			end
			pcfl_pkg::CMD_INIT: begin
				op.kind = pcfl_pkg::K_INIT;
				op.page = init_cnt;
			end
			default: begin
				op.kind = pcfl_pkg::K_REPORT;
			end
		endcase
	end

	assign op_data = op;

endmodule

// ===== rtl/pcfl_back.sv =====
// ----------------------------------------------------------------------------
// pcfl_back
// Executes classified operations on the list heads and the next-page RAM:
// push, pop with steal, the page-by-page init sweep, and status reports.
// ----------------------------------------------------------------------------
module pcfl_back #(
	parameter int NUM_CPUS   = 8,
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_empty,
	input  logic [4+((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1)+$clog2(MAX_PAGES+1)-1:0] op_data,
	output logic                 op_pop,
	input  logic [31:0]          base,
	input  logic                 res_full,
	output logic                 res_push,
	output pcfl_pkg::result_t    res_data
);

	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int PW = $clog2(MAX_PAGES + 1);
	localparam int AW = $clog2(MAX_PAGES);
	localparam int SH = $clog2(PAGE_BYTES);
	localparam logic [PW-1:0] NULL_PG = PW'(MAX_PAGES);

	localparam logic [1:0] S_IDLE       = 2'd0;
	localparam logic [1:0] S_ALLOC_WAIT = 2'd1;
	localparam logic [1:0] S_INIT       = 2'd2;

	typedef struct packed {
		logic [1:0]    kind;
		logic [1:0]    status;
		logic [CW-1:0] cpu;
		logic [PW-1:0] page;
	} op_t;

	op_t           op;
	logic [1:0]    state_q;
	logic [PW-1:0] heads_q [NUM_CPUS];
	logic [PW-1:0] page_q;
	logic [PW-1:0] idx_q;
	logic [PW-1:0] cnt_q;
	logic [CW-1:0] cpu_q;

	logic [NUM_CPUS-1:0] nonempty;
	logic [CW-1:0] first;
	logic [CW-1:0] src;
	logic          any;
	logic [CW-1:0] rd_sel;
	logic [PW-1:0] head_rd;
	logic          start;

	logic          hw_en;
	logic [CW-1:0] hw_sel;
	logic [PW-1:0] hw_val;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [PW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [PW-1:0] ram_rdata;

	logic [1:0]    next_state;
	logic [31:0]   page_off;

	assign op = op_data;

	always_comb begin
		for (int i = 0; i < NUM_CPUS; i++) begin
			nonempty[i] = (heads_q[i] != NULL_PG);
		end
	end

	// lowest-numbered non-empty list, used when the requester's list is dry
	always_comb begin
		first = '0;
		for (int i = NUM_CPUS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				first = CW'(i);
			end
		end
	end

	assign any     = |nonempty;
	assign src     = nonempty[op.cpu] ? op.cpu : first;
	assign rd_sel  = (state_q == S_INIT) ? cpu_q :
		((op.kind == pcfl_pkg::K_ALLOC) ? src : op.cpu);
	assign head_rd = heads_q[rd_sel];
	assign start   = (state_q == S_IDLE) && !op_empty && !res_full;
	assign op_pop  = start;

	assign page_off = 32'({page_q, {SH{1'b0}}});

	always_comb begin
		next_state = state_q;
		hw_en      = 1'b0;
		hw_sel     = rd_sel;
		hw_val     = '0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = head_rd;
		ram_raddr  = head_rd[AW-1:0];
		res_push   = 1'b0;
		res_data.status          = pcfl_pkg::ST_OK;
		res_data.granted_address = '0;
		res_data.source_cpu      = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op.kind)
						pcfl_pkg::K_REPORT: begin
							res_push        = 1'b1;
							res_data.status = op.status;
						end
						pcfl_pkg::K_PUSH: begin
							ram_we    = 1'b1;
							ram_waddr = op.page[AW-1:0];
							hw_en     = 1'b1;
							hw_val    = op.page;
							res_push  = 1'b1;
						end
						pcfl_pkg::K_ALLOC: begin
							if (any) begin
								next_state = S_ALLOC_WAIT;
							end else begin
								res_push        = 1'b1;
								res_data.status = pcfl_pkg::ST_NOMEM;
							end
						end
						pcfl_pkg::K_INIT: begin
							if (op.page == '0) begin
								res_push = 1'b1;
							end else begin
								next_state = S_INIT;
							end
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC_WAIT: begin
				// next-page entry of the popped head is back from the RAM
				hw_en                    = 1'b1;
				hw_sel                   = cpu_q;
				hw_val                   = ram_rdata;
				res_push                 = 1'b1;
				res_data.granted_address = base + page_off;
				res_data.source_cpu      = 3'(cpu_q);
				next_state               = S_IDLE;
			end
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				hw_en     = 1'b1;
				hw_val    = idx_q;
				if (idx_q == cnt_q - 1'b1) begin
					res_push   = 1'b1;
					next_state = S_IDLE;
				end
			end
			default: begin
				next_state = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NUM_CPUS; i++) begin
				heads_q[i] <= NULL_PG;
			end
		end else begin
			state_q <= next_state;
			if (hw_en) begin
				heads_q[hw_sel] <= hw_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			page_q <= head_rd;
			idx_q  <= '0;
			cnt_q  <= op.page;
			cpu_q  <= (op.kind == pcfl_pkg::K_ALLOC) ? src : op.cpu;
		end else if (state_q == S_INIT) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	pcfl_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_PAGES)
	) u_next_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	a_res_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	a_alloc_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC_WAIT) |-> $past(op_pop))
		else $error("alloc wait entered without taking an operation");

	a_init_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> (idx_q < cnt_q))
		else $error("init sweep ran past its page count");

	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !op_pop)
		else $error("operation taken while busy");

endmodule

// ===== rtl/per_cpu_page_free_list_top.sv =====
// Order: free, rejected free and unknown command are answered when the back end takes them;
// alloc is answered from S_ALLOC_WAIT after the next-page RAM read, init after its S_INIT sweep of N pages.
// Throughput: one item per cycle for free and report while the result queue has room; alloc and
// init keep the back end busy until done, and in S_INIT it writes one next-page entry a cycle.
// Reset: all lists empty, mem_base and mem_top at defaults; the next-page RAM is not
// cleared and needs no clearing pass, so items are taken right after reset.
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_top
// Per-CPU LIFO page allocator: front classifier, operation queue, back
// executor over list heads and next-page RAM, and a result queue.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_top #(
	parameter int NUM_CPUS   = 8,
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  pcfl_pkg::item_t                  item,
	output logic                             empty,
	input  logic                             pop,
	output pcfl_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pcfl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data
);

	localparam int CW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int PW   = $clog2(MAX_PAGES + 1);
	localparam int OP_W = 4 + CW + PW;
	localparam int RES_W = $bits(pcfl_pkg::result_t);

	logic [31:0]       mem_base_q;
	logic [31:0]       mem_top_q;
	logic [32:0]       base;
	logic [OP_W-1:0]   op_in;
	logic [OP_W-1:0]   op_out;
	logic              op_empty;
	logic              op_pop;
	logic              res_full;
	logic              res_push;
	pcfl_pkg::result_t res_data;
	logic [RES_W-1:0]  res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q <= pcfl_pkg::MEM_BASE_RST;
			mem_top_q  <= pcfl_pkg::MEM_TOP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pcfl_pkg::CFG_MEM_BASE: mem_base_q <= cfg_data;
				pcfl_pkg::CFG_MEM_TOP:  mem_top_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// round the managed base up to a page boundary; may reach 2^32
	assign base = (33'(mem_base_q) + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);

	pcfl_front #(
		.NUM_CPUS   (NUM_CPUS),
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_front (
		.item     (item),
		.mem_base (mem_base_q),
		.mem_top  (mem_top_q),
		.base     (base),
		.op_data  (op_in)
	);

	pcfl_fifo #(
		.WIDTH (OP_W),
		.DEPTH (2)
	) u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (op_in),
		.full   (full),
		.pop    (op_pop),
		.rdata  (op_out),
		.empty  (op_empty)
	);

	pcfl_back #(
		.NUM_CPUS   (NUM_CPUS),
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (op_empty),
		.op_data  (op_out),
		.op_pop   (op_pop),
		.base     (base[31:0]),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data)
	);

	pcfl_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign result = res_out;

endmodule
